/* design/trigger_holdoff_skip_density_router_assert.svh */
// Assertion helpers used by the router, which checks its own logic.
`ifndef TRIGGER_HOLDOFF_SKIP_DENSITY_ROUTER_ASSERT_SVH
`define TRIGGER_HOLDOFF_SKIP_DENSITY_ROUTER_ASSERT_SVH

// Check that a condition holds in the cycle after a trigger.
`define THSDR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check that a condition holds in the same cycle as a trigger.
`define THSDR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* design/thsdr_pkg.sv */
`default_nettype none

package thsdr_pkg;

   localparam int MAX_CH       = 4;
   localparam int NUM_CHANNELS = 4;
   localparam int TIME_WIDTH   = 32;

   localparam int NOW_WIDTH   = 32;
   localparam int RAND_WIDTH  = 7;
   localparam int CTRL_WIDTH  = 16;
   localparam int SUM_WIDTH   = CTRL_WIDTH + 1;
   localparam int MODE_WIDTH  = 2;
   localparam int INDEX_WIDTH = 3;

   // Density threshold: fire when random percent plus control value exceeds this.
   localparam logic [SUM_WIDTH-1:0] DENSITY_FULL = SUM_WIDTH'(100);

   localparam logic [MAX_CH-1:0] CHANNEL_MASK = MAX_CH'((1 << NUM_CHANNELS) - 1);

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_HOLDOFF = 2'd0,
      MODE_SKIP    = 2'd1,
      MODE_DENSITY = 2'd2,
      MODE_INVALID = 2'd3
   } mode_type;

   localparam logic [INDEX_WIDTH-1:0] CSR_CHANNEL_ENABLE = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] CSR_MODE_WORD      = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] CSR_CONTROL_CH0    = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] CSR_CONTROL_CH1    = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] CSR_CONTROL_CH2    = 3'd4;
   localparam logic [INDEX_WIDTH-1:0] CSR_CONTROL_CH3    = 3'd5;

   typedef struct packed {
      logic [MAX_CH-1:0]                       enable;
      logic [MAX_CH-1:0][MODE_WIDTH-1:0]       mode;
      logic [MAX_CH-1:0][CTRL_WIDTH-1:0]       control;
   } cfg_type;

   typedef struct packed {
      logic                  en;
      mode_type              mode;
      logic [CTRL_WIDTH-1:0] cv;
   } chan_cfg_type;

endpackage

`default_nettype wire

/* design/thsdr_if.sv */
`default_nettype none

interface thsdr_req_if import thsdr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [NOW_WIDTH-1:0]  now_ms;
   logic [RAND_WIDTH-1:0] rand_ch0;
   logic [RAND_WIDTH-1:0] rand_ch1;
   logic [RAND_WIDTH-1:0] rand_ch2;
   logic [RAND_WIDTH-1:0] rand_ch3;

   modport source (output valid, now_ms, rand_ch0, rand_ch1, rand_ch2, rand_ch3,
                   input ready);
   modport sink (input valid, now_ms, rand_ch0, rand_ch1, rand_ch2, rand_ch3,
                 output ready);
endinterface

interface thsdr_rsp_if import thsdr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MAX_CH-1:0] fire_mask;
   logic              bad_mode;

   modport source (output valid, fire_mask, bad_mode, input ready);
   modport sink (input valid, fire_mask, bad_mode, output ready);
endinterface

interface thsdr_csr_if import thsdr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] index;
   logic [CTRL_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/thsdr_csr.sv */
`default_nettype none

module thsdr_csr import thsdr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   thsdr_csr_if.sink   csr_if,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_CHANNEL_ENABLE: cfg_ff.enable <= csr_if.data[MAX_CH-1:0];
            CSR_MODE_WORD:      cfg_ff.mode <= csr_if.data[MAX_CH*MODE_WIDTH-1:0];
            CSR_CONTROL_CH0:    cfg_ff.control[0] <= csr_if.data;
            CSR_CONTROL_CH1:    cfg_ff.control[1] <= csr_if.data;
            CSR_CONTROL_CH2:    cfg_ff.control[2] <= csr_if.data;
            CSR_CONTROL_CH3:    cfg_ff.control[3] <= csr_if.data;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/thsdr_channel.sv */
`default_nettype none

module thsdr_channel import thsdr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  chan_cfg_type          cfg,
   input  logic [TIME_WIDTH-1:0] now_time,
   input  logic [RAND_WIDTH-1:0] rand_pct,
   output logic                  fire,
   output logic                  bad
);

   logic [TIME_WIDTH-1:0] deadline_ff;
   logic [TIME_WIDTH-1:0] deadline_in;
   logic [CTRL_WIDTH-1:0] count_ff;
   logic [CTRL_WIDTH-1:0] count_in;
   logic [SUM_WIDTH-1:0]  density_sum;

   assign density_sum = SUM_WIDTH'(cfg.cv) + SUM_WIDTH'(rand_pct);

   always_comb begin
      fire        = 1'b0;
      bad         = 1'b0;
      deadline_in = deadline_ff;
      count_in    = count_ff;
      if (cfg.en) begin
         case (cfg.mode)
            MODE_HOLDOFF: begin
               if (now_time > deadline_ff) begin
                  fire        = 1'b1;
                  deadline_in = now_time + TIME_WIDTH'(cfg.cv);
               end
            end
            MODE_SKIP: begin
               fire     = (count_ff == '0);
               // clear once the count reaches the control value, else advance
               count_in = (count_ff >= cfg.cv) ? '0 : count_ff + CTRL_WIDTH'(1);
            end
            MODE_DENSITY: begin
               fire = (density_sum > DENSITY_FULL);
            end
            default: begin
               bad = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= '0;
         count_ff    <= '0;
      end else if (update) begin
         deadline_ff <= deadline_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

/* design/trigger_holdoff_skip_density_router.sv */
// Trigger router: each transaction on req_if is one trigger event (a millisecond
// timestamp and one random percent per channel) and yields exactly one
// transaction on rsp_if with the mask of channels that fired and a flag for an
// enabled channel set to the invalid mode. Channels condition the event by
// holdoff (fire when the time is strictly past the deadline, then move the
// deadline to time plus control value, wrapping), skip (fire when the counter is
// zero, clear it once it reaches the control value) or density (fire when the
// random percent plus the control value exceeds 100). Disabled channels neither
// fire nor change state. The block takes one event per clock while rsp_if keeps
// taking results; each result passes through two register stages (input
// register, then the result register). Each channel's read-modify-write of its
// deadline and counter sits between them. The input register also serves as a
// skid stage, so a new event is taken while an earlier result waits on rsp_if.
// Write configuration through csr_if only while no event is in flight.
`default_nettype none

`include "trigger_holdoff_skip_density_router_assert.svh"

module trigger_holdoff_skip_density_router import thsdr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   thsdr_req_if.sink     req_if,
   thsdr_rsp_if.source   rsp_if,
   thsdr_csr_if.sink     csr_if
);

   cfg_type cfg;

   // Input register stage.
   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [NOW_WIDTH-1:0]              now_ff;
   logic [MAX_CH-1:0][RAND_WIDTH-1:0] rand_ff;

   // Result register stage.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [MAX_CH-1:0] fire_mask_ff;
   logic              bad_mode_ff;

   logic                  advance;
   logic                  accept;
   logic [TIME_WIDTH-1:0] now_time;
   logic [MAX_CH-1:0]     fire_vec;
   logic [MAX_CH-1:0]     bad_vec;

   thsdr_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // Move the held event into the result register when that register is free
   // or is being drained this cycle.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   assign in_valid_in  = req_if.ready ? req_if.valid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the event payload until it advances.
   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff     <= req_if.now_ms;
         rand_ff[0] <= req_if.rand_ch0;
         rand_ff[1] <= req_if.rand_ch1;
         rand_ff[2] <= req_if.rand_ch2;
         rand_ff[3] <= req_if.rand_ch3;
      end
   end

   // Timestamp at the channel time width; wraps the same as the deadlines.
   assign now_time = TIME_WIDTH'(now_ff);

   // One conditioning unit per implemented channel; state updates only when the
   // event advances, so each event sees what the previous one left.
   for (genvar c = 0; c < MAX_CH; c++) begin : g_chan
      if (c < NUM_CHANNELS) begin : g_used
         chan_cfg_type chan_cfg;

         assign chan_cfg.en   = cfg.enable[c];
         assign chan_cfg.mode = mode_type'(cfg.mode[c]);
         assign chan_cfg.cv   = cfg.control[c];

         thsdr_channel u_channel (
            .clock    (clock),
            .reset    (reset),
            .update   (advance),
            .cfg      (chan_cfg),
            .now_time (now_time),
            .rand_pct (rand_ff[c]),
            .fire     (fire_vec[c]),
            .bad      (bad_vec[c])
         );
      end else begin : g_unused
         assign fire_vec[c] = 1'b0;
         assign bad_vec[c]  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fire_mask_ff <= fire_vec;
         bad_mode_ff  <= |bad_vec;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.fire_mask = fire_mask_ff;
   assign rsp_if.bad_mode  = bad_mode_ff;

   // An advancing event always lands in the result register.
   `THSDR_ASSERT_NEXT(a_advance_loads_rsp, advance, rsp_valid_ff,
      "advanced event did not reach the result register")

   // A stalled result keeps the held event in the input register.
   `THSDR_ASSERT_NEXT(a_stall_holds_input,
      in_valid_ff && rsp_valid_ff && !rsp_if.ready, in_valid_ff,
      "held event dropped while the result was stalled")

   // Channels beyond the implemented count never fire.
   `THSDR_ASSERT_SAME(a_unused_quiet, rsp_valid_ff,
      (fire_mask_ff & ~CHANNEL_MASK) == '0,
      "unimplemented channel fired")

endmodule

`default_nettype wire

/* tb/sv/thsdr_tb_pkg.sv */
package thsdr_tb_pkg;
   import thsdr_pkg::*;

   // Indexes with no register behind them; writes there must change nothing.
   localparam logic [INDEX_WIDTH-1:0] CSR_UNUSED_A = 3'd6;
   localparam logic [INDEX_WIDTH-1:0] CSR_UNUSED_B = 3'd7;

   typedef struct packed {
      logic [NOW_WIDTH-1:0]                  now_ms;
      logic [MAX_CH-1:0][RAND_WIDTH-1:0]     pct;
   } trigger_type;

   typedef struct packed {
      logic [MAX_CH-1:0] fire_mask;
      logic              bad_mode;
   } route_outcome_type;

   // Tracks channel state and configuration, and holds the outcomes still owed.
   class trigger_route_scoreboard;
      logic [MAX_CH-1:0]                 enable;
      logic [MAX_CH-1:0][MODE_WIDTH-1:0] mode;
      logic [CTRL_WIDTH-1:0]             control [MAX_CH];
      logic [TIME_WIDTH-1:0]             deadline [MAX_CH];
      logic [CTRL_WIDTH-1:0]             skip_count [MAX_CH];
      route_outcome_type                 owed_outcomes [$];
      int                                errors;

      function new();
         enable = '0;
         mode   = '0;
         errors = 0;
         for (int c = 0; c < MAX_CH; c++) begin
            control[c]    = '0;
            deadline[c]   = '0;
            skip_count[c] = '0;
         end
      endfunction

      function void write_reg(logic [INDEX_WIDTH-1:0] idx, logic [CTRL_WIDTH-1:0] value);
         case (idx)
            CSR_CHANNEL_ENABLE: enable = value[MAX_CH-1:0];
            CSR_MODE_WORD:      mode = value[MAX_CH*MODE_WIDTH-1:0];
            CSR_CONTROL_CH0:    control[0] = value;
            CSR_CONTROL_CH1:    control[1] = value;
            CSR_CONTROL_CH2:    control[2] = value;
            CSR_CONTROL_CH3:    control[3] = value;
            default: ;
         endcase
      endfunction

      function void predict_trigger(trigger_type t);
         route_outcome_type     outcome;
         logic [TIME_WIDTH-1:0] now;
         logic [SUM_WIDTH-1:0]  level;
         now     = TIME_WIDTH'(t.now_ms);
         outcome = '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (enable[c]) begin
               case (mode_type'(mode[c]))
                  MODE_HOLDOFF: begin
                     if (now > deadline[c]) begin
                        outcome.fire_mask[c] = 1'b1;
                        deadline[c] = now + TIME_WIDTH'(control[c]);
                     end
                  end
                  MODE_SKIP: begin
                     if (skip_count[c] == '0)
                        outcome.fire_mask[c] = 1'b1;
                     if (skip_count[c] >= control[c])
                        skip_count[c] = '0;
                     else
                        skip_count[c] = skip_count[c] + 1'b1;
                  end
                  MODE_DENSITY: begin
                     level = SUM_WIDTH'(t.pct[c]) + SUM_WIDTH'(control[c]);
                     if (level > DENSITY_FULL)
                        outcome.fire_mask[c] = 1'b1;
                  end
                  default: outcome.bad_mode = 1'b1;
               endcase
            end
         end
         owed_outcomes.push_back(outcome);
      endfunction

      function void check_result(logic [MAX_CH-1:0] fire_mask, logic bad_mode);
         route_outcome_type want;
         if (owed_outcomes.size() == 0) begin
            $error("result with no trigger outstanding: fire_mask %h bad_mode %b",
                   fire_mask, bad_mode);
            errors++;
            return;
         end
         want = owed_outcomes.pop_front();
         if (fire_mask !== want.fire_mask) begin
            $error("fire_mask: expected %h, actual %h", want.fire_mask, fire_mask);
            errors++;
         end
         if (bad_mode !== want.bad_mode) begin
            $error("bad_mode: expected %b, actual %b", want.bad_mode, bad_mode);
            errors++;
         end
      endfunction

      function int pending();
         return owed_outcomes.size();
      endfunction
   endclass

endpackage

/* tb/sv/tb_top.sv */
module tb_top;
   import thsdr_pkg::*;
   import thsdr_tb_pkg::*;

   // Pipeline is two deep; the settle wait covers it before any register write.
   localparam int SETTLE_CYCLES    = 4;
   // Cycles without any transaction on any channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 175;

   logic clock;
   logic reset;

   thsdr_req_if req_if();
   thsdr_rsp_if rsp_if();
   thsdr_csr_if csr_if();

   trigger_holdoff_skip_density_router dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   trigger_route_scoreboard sb;
   bit                      quiet;        // suppress idling on both sides
   logic [NOW_WIDTH-1:0]    now_cursor;   // running timestamp for random triggers
   int unsigned             idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic trigger_type ev(input logic [NOW_WIDTH-1:0] now,
                                      input logic [RAND_WIDTH-1:0] p0, p1, p2, p3);
      trigger_type t;
      t.now_ms = now;
      t.pct[0] = p0;
      t.pct[1] = p1;
      t.pct[2] = p2;
      t.pct[3] = p3;
      return t;
   endfunction

   function automatic mode_type pick_mode();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return MODE_HOLDOFF;
      if (r < 60)
         return MODE_SKIP;
      if (r < 90)
         return MODE_DENSITY;
      return MODE_INVALID;
   endfunction

   // Keep control values mostly in the range where the mode actually toggles.
   function automatic logic [CTRL_WIDTH-1:0] pick_ctrl(input mode_type m);
      int unsigned r;
      r = $urandom_range(0, 99);
      case (m)
         MODE_HOLDOFF: begin
            if (r < 70) return CTRL_WIDTH'($urandom_range(0, 40));
            if (r < 90) return CTRL_WIDTH'($urandom_range(0, 1000));
         end
         MODE_SKIP: begin
            if (r < 70) return CTRL_WIDTH'($urandom_range(0, 6));
            if (r < 90) return CTRL_WIDTH'($urandom_range(0, 300));
         end
         MODE_DENSITY: begin
            if (r < 80) return CTRL_WIDTH'($urandom_range(0, 101));
            if (r < 90) return CTRL_WIDTH'($urandom_range(101, 200));
         end
         default: ;
      endcase
      return CTRL_WIDTH'($urandom);
   endfunction

   // Advance the timestamp: small steps dominate so holdoff deadlines are hit
   // exactly and just past; occasional repeats, steps back, jumps and near-wrap.
   function automatic trigger_type random_trigger();
      trigger_type t;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         now_cursor = now_cursor + $urandom_range(0, 8);
      else if (r < 80)
         now_cursor = now_cursor + $urandom_range(9, 200);
      else if (r < 90)
         now_cursor = now_cursor - $urandom_range(1, 50);
      else if (r < 96)
         now_cursor = $urandom;
      else
         now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 20);
      t.now_ms = now_cursor;
      for (int c = 0; c < MAX_CH; c++) begin
         // Percent values above 99 are legal on the wire and used as given.
         if ($urandom_range(0, 99) < 85)
            t.pct[c] = RAND_WIDTH'($urandom_range(0, 99));
         else
            t.pct[c] = RAND_WIDTH'($urandom_range(100, 127));
      end
      return t;
   endfunction

   // Hold valid until the block takes the trigger; leave valid high on exit so a
   // back-to-back trigger never drops it between the two.
   task automatic send_trigger(input trigger_type t);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.now_ms   <= t.now_ms;
      req_if.rand_ch0 <= t.pct[0];
      req_if.rand_ch1 <= t.pct[1];
      req_if.rand_ch2 <= t.pct[2];
      req_if.rand_ch3 <= t.pct[3];
      do @(posedge clock); while (!req_if.ready);
      sb.predict_trigger(t);
   endtask

   // Drop valid, wait for every owed result, then let the pipeline empty.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx,
                            input logic [CTRL_WIDTH-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, value);
   endtask

   // Write the full register set while idle; junk in the unused upper bits of
   // the narrow registers must be ignored by the block.
   task automatic configure(input logic [MAX_CH-1:0] en,
                            input logic [MAX_CH*MODE_WIDTH-1:0] mw,
                            input logic [CTRL_WIDTH-1:0] cv0, cv1, cv2, cv3,
                            input bit poke_unused);
      logic [CTRL_WIDTH-1:0] word;
      drain();
      word = CTRL_WIDTH'($urandom);
      word[MAX_CH-1:0] = en;
      write_reg(CSR_CHANNEL_ENABLE, word);
      word = CTRL_WIDTH'($urandom);
      word[MAX_CH*MODE_WIDTH-1:0] = mw;
      write_reg(CSR_MODE_WORD, word);
      write_reg(CSR_CONTROL_CH0, cv0);
      write_reg(CSR_CONTROL_CH1, cv1);
      write_reg(CSR_CONTROL_CH2, cv2);
      write_reg(CSR_CONTROL_CH3, cv3);
      if (poke_unused) begin
         write_reg(CSR_UNUSED_A, CTRL_WIDTH'($urandom));
         write_reg(CSR_UNUSED_B, CTRL_WIDTH'($urandom));
      end
      csr_if.valid <= 1'b0;
   endtask

   // Phase 0 pins every control value at its maximum, phase 1 at zero.
   task automatic random_config(input int phase);
      logic [MAX_CH-1:0]                 en;
      logic [MAX_CH-1:0][MODE_WIDTH-1:0] mw;
      logic [CTRL_WIDTH-1:0]             cv [MAX_CH];
      mode_type                          m;
      en = ($urandom_range(0, 99) < 60) ? '1 : MAX_CH'($urandom);
      for (int c = 0; c < MAX_CH; c++) begin
         m     = pick_mode();
         mw[c] = m;
         if (phase == 0)
            cv[c] = '1;
         else if (phase == 1)
            cv[c] = '0;
         else
            cv[c] = pick_ctrl(m);
      end
      configure(en, mw, cv[0], cv[1], cv[2], cv[3], $urandom_range(0, 3) == 0);
   endtask

   // Result side: ready idles with random gaps, sole driver of rsp_if.ready.
   initial begin
      int unsigned hold;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Check every accepted result against the oldest owed outcome.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.fire_mask, rsp_if.bad_mode);
   end

   // Watchdog: any transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      sb         = new();
      quiet      = 1'b0;
      now_cursor = '0;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.now_ms   <= '0;
      req_if.rand_ch0 <= '0;
      req_if.rand_ch1 <= '0;
      req_if.rand_ch2 <= '0;
      req_if.rand_ch3 <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= '0;
      csr_if.data     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Out of reset every channel is disabled: nothing fires, whatever the input.
      send_trigger(ev(32'h0000_0000, 0, 0, 0, 0));
      send_trigger(ev(32'hFFFF_FFFF, 127, 127, 127, 127));

      // One channel per mode, channel 3 invalid so bad_mode rises every event.
      // Holdoff of 10: time 0 equals the reset deadline and must not fire,
      // 1 fires, 11 sits on the new deadline, 12 is just past it.
      // Density at 50: percent 50 lands exactly on 100 and must not fire.
      configure(4'hF, {MODE_INVALID, MODE_DENSITY, MODE_SKIP, MODE_HOLDOFF},
                16'd10, 16'd2, 16'd50, 16'd0, 1'b0);
      send_trigger(ev(32'd0, 0, 0, 50, 0));
      send_trigger(ev(32'd1, 99, 99, 51, 99));
      send_trigger(ev(32'd11, 0, 0, 0, 0));
      send_trigger(ev(32'd12, 127, 127, 127, 127));

      // Invalid mode on disabled channels must not raise bad_mode.
      configure(4'h1, {MODE_INVALID, MODE_INVALID, MODE_INVALID, MODE_HOLDOFF},
                16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_trigger(ev(32'd100, 0, 0, 0, 0));

      // Holdoff at maximum: deadline wraps past 2^32 and lands low.
      configure(4'hF, {4{MODE_HOLDOFF}}, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_trigger(ev(32'hFFFF_FFFF, 0, 0, 0, 0));
      send_trigger(ev(32'h0000_0000, 0, 0, 0, 0));
      send_trigger(ev(32'h0000_FFFE, 0, 0, 0, 0));
      send_trigger(ev(32'h0000_FFFF, 0, 0, 0, 0));

      // Density extremes: control 0, 100, 101 and maximum; percent above 99.
      configure(4'hF, {4{MODE_DENSITY}}, 16'd0, 16'd100, 16'd101, 16'hFFFF, 1'b0);
      send_trigger(ev(32'd5, 127, 0, 0, 0));
      send_trigger(ev(32'd6, 100, 1, 99, 0));

      // Skip with control 0 (fires every event), 1, maximum and 3.
      configure(4'hF, {4{MODE_SKIP}}, 16'd0, 16'd1, 16'hFFFF, 16'd3, 1'b1);
      repeat (3) send_trigger(ev(32'd7, 0, 0, 0, 0));
      // Lower channel 3 below its running count: it must clear on the next event.
      configure(4'hF, {4{MODE_SKIP}}, 16'd0, 16'd1, 16'hFFFF, 16'd1, 1'b1);
      repeat (2) send_trigger(ev(32'd8, 0, 0, 0, 0));

      // Random phases, each under a fresh configuration; every third one runs
      // with no idling on either side. Phase 0 starts the clock near the wrap.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiet = (p % 3 == 2);
         if (p == 0)
            now_cursor = 32'hFFFF_FF00;
         random_config(p);
         repeat (ITEMS_PER_PHASE) send_trigger(random_trigger());
      end

      quiet = 1'b0;
      drain();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/thsdr_pkg.sv
design/thsdr_if.sv
design/thsdr_csr.sv
design/thsdr_channel.sv
design/trigger_holdoff_skip_density_router.sv
tb/sv/thsdr_tb_pkg.sv
tb/sv/tb_top.sv
